FILE: rtl/core/mcm_pkg.sv
// shared types, constants and sine table functions of the metronome click mixer
package mcm_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CLICK_W   = 18;
    localparam int MAG_W     = 17;
    localparam int SINE_W    = 15;
    localparam int ANGLE_W   = 24;
    localparam int QUAD_LO   = 22;
    localparam int DROP_W    = 17;
    localparam int SPB_W     = 18;
    localparam int CLEN_W    = 16;
    localparam int VOL_W     = 16;
    localparam int CNT_W     = 2;
    localparam int PROD_W    = SINE_W + VOL_W;
    localparam int ROUND_SH  = 15;

    localparam int NUM_LANES    = 2;
    localparam int MAX_CHANNELS = 2;
    localparam int LANE_LIMIT   = (MAX_CHANNELS < NUM_LANES) ? MAX_CHANNELS : NUM_LANES;

    localparam int PHASE_BITS_DEF = 18;
    localparam int SINE_DEPTH_DEF = 256;

    localparam logic [DROP_W-1:0] DROP_MAX   = '1;
    localparam logic [SINE_W-1:0] SINE_PEAK  = '1;
    localparam logic [63:0]       PI_HALF_Q30 = 64'd1686629713;

    // register map, index = paddr[4:2]
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam logic [2:0] REG_ENABLE    = 3'd0;
    localparam logic [2:0] REG_SPB       = 3'd1;
    localparam logic [2:0] REG_CLICK_LEN = 3'd2;
    localparam logic [2:0] REG_TONE_STEP = 3'd3;
    localparam logic [2:0] REG_VOLUME    = 3'd4;
    localparam logic [2:0] REG_ENV_STEP  = 3'd5;
    localparam logic [2:0] REG_CH_COUNT  = 3'd6;

    typedef struct packed {
        logic                enable;
        logic [SPB_W-1:0]    spb;
        logic [CLEN_W-1:0]   click_len;
        logic [ANGLE_W-1:0]  tone_step;
        logic [VOL_W-1:0]    volume;
        logic [VOL_W-1:0]    env_step;
        logic [CNT_W-1:0]    ch_count;
    } cfg_t;

    typedef struct packed {
        logic                click_on;
        logic [ANGLE_W-1:0]  angle;
        logic [DROP_W-1:0]   drop;
    } tone_req_t;

    typedef struct packed {
        logic [NUM_LANES-1:0][SAMPLE_W-1:0] samples;
        logic                               beat;
        logic                               last;
    } frame_t;

    // sine of a Q30 angle in 0..pi/2, Taylor series to the fifteenth power
    function automatic logic [63:0] sine_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - term;
        return sum;
    endfunction

    function automatic logic [SINE_W-1:0] rom_entry(input logic [63:0] x);
        logic [63:0] v;
        v = (sine_q30(x) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[SINE_W-1:0];
    endfunction

endpackage

FILE: rtl/core/mcm_beat.sv
// beat phase, tone angle and envelope drop sequencer
module mcm_beat
    import mcm_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      accept,
    input  logic      restart,
    output tone_req_t req,
    output logic      beat_start
);

    localparam int NEXT_W = PHASE_BITS + 1;
    localparam int CMP_W  = (NEXT_W > SPB_W) ? NEXT_W : SPB_W;
    localparam int CL_W   = (PHASE_BITS > CLEN_W) ? PHASE_BITS : CLEN_W;

    logic [PHASE_BITS-1:0] phase_reg, phase_next, phase_base;
    logic [ANGLE_W-1:0]    angle_reg, angle_next, angle_base;
    logic [DROP_W-1:0]     drop_reg, drop_next, drop_base;
    logic [NEXT_W-1:0]     phase_inc;
    logic [DROP_W:0]       drop_sum;
    logic                  wrap;
    tone_req_t             req_reg, req_next;

    always_comb
    begin
        // restart clears the state before the frame is handled
        phase_base = restart ? '0 : phase_reg;
        angle_base = restart ? '0 : angle_reg;
        drop_base  = restart ? '0 : drop_reg;

        phase_inc = {1'b0, phase_base} + NEXT_W'(1);
        wrap      = phase_inc[PHASE_BITS] || (CMP_W'(phase_inc) >= CMP_W'(cfg.spb));
        drop_sum  = {1'b0, drop_base} + (DROP_W + 1)'(cfg.env_step);

        phase_next = phase_base;
        angle_next = angle_base;
        drop_next  = drop_base;
        if (cfg.enable)
        begin
            if (wrap)
            begin
                phase_next = '0;
                angle_next = '0;
                drop_next  = '0;
            end
            else
            begin
                phase_next = phase_inc[PHASE_BITS-1:0];
                angle_next = angle_base + cfg.tone_step;
                drop_next  = drop_sum[DROP_W] ? DROP_MAX : drop_sum[DROP_W-1:0];
            end
        end

        req_next.click_on = cfg.enable && (CL_W'(phase_next) < CL_W'(cfg.click_len));
        req_next.angle    = angle_next;
        req_next.drop     = drop_next;

        beat_start = cfg.enable && wrap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            angle_reg <= '0;
            drop_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            angle_reg <= angle_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_next;
        end
    end

    assign req = req_reg;

endmodule

FILE: rtl/core/mcm_tone.sv
// quarter-wave sine lookup and envelope scaling of the click tone
module mcm_tone
    import mcm_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic [VOL_W-1:0]          volume,
    input  tone_req_t                 req,
    input  logic                      load_rom,
    input  logic                      load_mul,
    output logic signed [CLICK_W-1:0] click
);

    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int FRAC_W = QUAD_LO;

    logic [SINE_W-1:0] sine_rom [SINE_TABLE_DEPTH + 1];

    for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++)
    begin : g_rom
        if (i == SINE_TABLE_DEPTH)
        begin : g_peak
            assign sine_rom[i] = SINE_PEAK;
        end
        else
        begin : g_entry
            localparam logic [63:0] X = (64'(i) * PI_HALF_Q30) / SINE_TABLE_DEPTH;
            assign sine_rom[i] = rom_entry(X);
        end
    end

    logic [1:0]              quad;
    logic [FRAC_W+IDX_W-1:0] idx_prod;
    logic [IDX_W-1:0]        idx, rd_idx;
    logic [DROP_W-1:0]       amp_diff;
    logic [VOL_W-1:0]        amp;
    logic [SINE_W-1:0]       sine_reg;
    logic [VOL_W-1:0]        amp_reg;
    logic                    neg_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    neg_mul_reg;
    logic [PROD_W:0]         rounded;
    logic [CLICK_W-1:0]      mag;

    always_comb
    begin
        quad     = req.angle[ANGLE_W-1:QUAD_LO];
        idx_prod = (FRAC_W + IDX_W)'(req.angle[QUAD_LO-1:0])
                 * (FRAC_W + IDX_W)'(SINE_TABLE_DEPTH);
        idx      = idx_prod[FRAC_W +: IDX_W];
        // odd quadrants run the table backwards
        rd_idx   = quad[0] ? IDX_W'(SINE_TABLE_DEPTH) - idx : idx;

        amp_diff = {1'b0, volume} - req.drop;
        if (req.click_on && ({1'b0, volume} > req.drop))
        begin
            amp = amp_diff[VOL_W-1:0];
        end
        else
        begin
            amp = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_rom)
        begin
            sine_reg <= sine_rom[rd_idx];
            amp_reg  <= amp;
            neg_reg  <= quad[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_mul)
        begin
            prod_reg    <= PROD_W'(sine_reg) * PROD_W'(amp_reg);
            neg_mul_reg <= neg_reg;
        end
    end

    // round half up in magnitude, then apply the quadrant sign
    always_comb
    begin
        rounded = {1'b0, prod_reg} + (PROD_W + 1)'(1 << (ROUND_SH - 1));
        mag     = CLICK_W'(rounded[PROD_W:ROUND_SH]);
        click   = neg_mul_reg ? -$signed(mag) : $signed(mag);
    end

endmodule

FILE: rtl/core/mcm_lane.sv
// one channel lane: adds the click when active and saturates to 16 bits
module mcm_lane
    import mcm_pkg::*;
(
    input  logic [SAMPLE_W-1:0]       sample,
    input  logic signed [CLICK_W-1:0] click,
    input  logic                      active,
    output logic [SAMPLE_W-1:0]       mixed
);

    localparam int SUM_W = CLICK_W + 1;
    localparam logic signed [SUM_W-1:0] POS_LIM = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] NEG_LIM = -SUM_W'(32768);

    logic signed [SUM_W-1:0] sum;

    always_comb
    begin
        sum = SUM_W'($signed(sample));
        if (active)
        begin
            sum = sum + SUM_W'(click);
        end
        if (sum > POS_LIM)
        begin
            mixed = 16'h7FFF;
        end
        else if (sum < NEG_LIM)
        begin
            mixed = 16'h8000;
        end
        else
        begin
            mixed = sum[SAMPLE_W-1:0];
        end
    end

endmodule

FILE: rtl/core/metronome_click_mixer.sv
// metronome click mixer: takes one frame per cycle while the output does not stall; a frame
// reaches the output register having passed four register stages (phase sequencer, sine table
// read, amplitude multiply, lane mix and saturation), and back pressure from the output stalls
// only the stages that are full; the user is to write registers over the apb port only while
// no frame is in flight, the block itself does not enforce this
module metronome_click_mixer
    import mcm_pkg::*;
#(
    parameter int PHASE_BITS       = PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,

    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,   // sample_ch0, sample_ch1
    input  logic              s_axis_tuser,   // restart
    input  logic              s_axis_tlast,   // end_of_block

    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // mixed_ch0, mixed_ch1
    output logic              m_axis_tuser,   // beat_start
    output logic              m_axis_tlast    // block_end
);

    // configuration registers
    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable    <= 1'b0;
            cfg_reg.spb       <= SPB_W'(24000);
            cfg_reg.click_len <= CLEN_W'(480);
            cfg_reg.tone_step <= ANGLE_W'(349525);
            cfg_reg.volume    <= VOL_W'(16384);
            cfg_reg.env_step  <= VOL_W'(34);
            cfg_reg.ch_count  <= CNT_W'(2);
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_ENABLE:    cfg_reg.enable    <= pwdata[0];
                REG_SPB:       cfg_reg.spb       <= pwdata[SPB_W-1:0];
                REG_CLICK_LEN: cfg_reg.click_len <= pwdata[CLEN_W-1:0];
                REG_TONE_STEP: cfg_reg.tone_step <= pwdata[ANGLE_W-1:0];
                REG_VOLUME:    cfg_reg.volume    <= pwdata[VOL_W-1:0];
                REG_ENV_STEP:  cfg_reg.env_step  <= pwdata[VOL_W-1:0];
                REG_CH_COUNT:  cfg_reg.ch_count  <= pwdata[CNT_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ENABLE:    prdata = DATA_W'(cfg_reg.enable);
            REG_SPB:       prdata = DATA_W'(cfg_reg.spb);
            REG_CLICK_LEN: prdata = DATA_W'(cfg_reg.click_len);
            REG_TONE_STEP: prdata = DATA_W'(cfg_reg.tone_step);
            REG_VOLUME:    prdata = DATA_W'(cfg_reg.volume);
            REG_ENV_STEP:  prdata = DATA_W'(cfg_reg.env_step);
            REG_CH_COUNT:  prdata = DATA_W'(cfg_reg.ch_count);
            default:       prdata = '0;
        endcase
    end

    // pipeline flow control, each stage moves on when the next one is free
    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic rdy_out, rdy3, rdy2, rdy1;
    logic adv0, adv1, adv2, adv3;

    assign rdy_out = !out_valid_reg || m_axis_tready;
    assign rdy3    = !v3_reg || rdy_out;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign adv0    = s_axis_tvalid && rdy1;
    assign adv1    = v1_reg && rdy2;
    assign adv2    = v2_reg && rdy3;
    assign adv3    = v3_reg && rdy_out;

    assign s_axis_tready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv0)
                v1_reg <= 1'b1;
            else if (adv1)
                v1_reg <= 1'b0;
            if (adv1)
                v2_reg <= 1'b1;
            else if (adv2)
                v2_reg <= 1'b0;
            if (adv2)
                v3_reg <= 1'b1;
            else if (adv3)
                v3_reg <= 1'b0;
            if (adv3)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // frame sideband follows the tone through the stages
    tone_req_t tone_req;
    logic      beat_start;
    frame_t    frame1_reg, frame2_reg, frame3_reg;

    mcm_beat #(
        .PHASE_BITS (PHASE_BITS)
    ) u_beat (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .accept     (adv0),
        .restart    (s_axis_tuser),
        .req        (tone_req),
        .beat_start (beat_start)
    );

    always_ff @(posedge clk)
    begin
        if (adv0)
        begin
            frame1_reg.samples <= s_axis_tdata;
            frame1_reg.beat    <= beat_start;
            frame1_reg.last    <= s_axis_tlast;
        end
        if (adv1)
        begin
            frame2_reg <= frame1_reg;
        end
        if (adv2)
        begin
            frame3_reg <= frame2_reg;
        end
    end

    logic signed [CLICK_W-1:0] click;

    mcm_tone #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_tone (
        .clk      (clk),
        .volume   (cfg_reg.volume),
        .req      (tone_req),
        .load_rom (adv1),
        .load_mul (adv2),
        .click    (click)
    );

    // lanes mix the click into each active channel, merged into the output register
    logic [NUM_LANES-1:0][SAMPLE_W-1:0] lane_out;

    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        logic lane_active;

        assign lane_active = (l < LANE_LIMIT) && (CNT_W'(l) < cfg_reg.ch_count);

        mcm_lane u_lane (
            .sample (frame3_reg.samples[l]),
            .click  (click),
            .active (lane_active),
            .mixed  (lane_out[l])
        );
    end

    logic [NUM_LANES-1:0][SAMPLE_W-1:0] out_data_reg;
    logic                               out_beat_reg;
    logic                               out_last_reg;

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            out_data_reg <= lane_out;
            out_beat_reg <= frame3_reg.beat;
            out_last_reg <= frame3_reg.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_beat_reg;
    assign m_axis_tlast  = out_last_reg;

    // an empty output register never holds back the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty output register");

    // a transfer always lands in the first stage
    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        adv0 |=> v1_reg)
        else $error("accepted frame lost before first stage");

    // a blocked last stage keeps its click value
    a_click_held: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !rdy_out |=> v3_reg && $stable(click))
        else $error("click changed while mix stage stalled");

endmodule

FILE: bench/testbench.sv
// self-checking bench for the metronome click mixer: stream driver, monitor and frame predictor
`timescale 1ns / 1ps

module testbench;
    import mcm_pkg::*;

    localparam int PHASE_LIMIT = (1 << PHASE_BITS_DEF) - 1;

    typedef struct {
        logic [SAMPLE_W-1:0] ch0;
        logic [SAMPLE_W-1:0] ch1;
        logic                restart;
        logic                eob;
    } dry_frame_t;

    typedef struct {
        logic [SAMPLE_W-1:0] ch0;
        logic [SAMPLE_W-1:0] ch1;
        logic                beat;
        logic                eob;
    } mixed_frame_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;   // sample_ch0, sample_ch1
    logic              s_axis_tuser = 1'b0; // restart
    logic              s_axis_tlast = 1'b0; // end_of_block
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;        // mixed_ch0, mixed_ch1
    logic              m_axis_tuser;        // beat_start
    logic              m_axis_tlast;        // block_end

    metronome_click_mixer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor copy of the registers and the beat state
    cfg_t                click_cfg;
    logic [SPB_W-1:0]    beat_phase;
    logic [ANGLE_W-1:0]  tone_angle;
    logic [DROP_W-1:0]   envelope_drop;
    logic [SINE_W-1:0]   sine_table [0:SINE_DEPTH_DEF];

    dry_frame_t   pending_frames[$];
    mixed_frame_t expected_mixes[$];
    dry_frame_t   current_frame;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           mismatch_count = 0;

    function automatic logic [63:0] quarter_sine_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int k = 1; k <= 7; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic logic [SAMPLE_W-1:0] clamp16(input int v);
        if (v > 32767)
        begin
            return 16'h7FFF;
        end
        if (v < -32768)
        begin
            return 16'h8000;
        end
        return v[SAMPLE_W-1:0];
    endfunction

    // one frame through the beat sequencer, tone generator and lane mixer
    function automatic mixed_frame_t mix_frame(input dry_frame_t f);
        logic [SPB_W:0]   next_phase;
        logic [DROP_W:0]  drop_sum;
        logic [1:0]       quad;
        int               idx;
        logic [DROP_W-1:0] amp;
        logic [SINE_W-1:0] sv;
        logic [32:0]      prod;
        logic [MAG_W-1:0] mag;
        int               click;
        int               active;
        int               lane [NUM_LANES];
        mixed_frame_t     r;
        lane[0] = int'($signed(f.ch0));
        lane[1] = int'($signed(f.ch1));
        click   = 0;
        r.beat  = 1'b0;
        if (f.restart)
        begin
            beat_phase    = '0;
            tone_angle    = '0;
            envelope_drop = '0;
        end
        if (click_cfg.enable)
        begin
            next_phase = {1'b0, beat_phase} + 1'b1;
            if (next_phase >= click_cfg.spb || next_phase > PHASE_LIMIT)
            begin
                beat_phase    = '0;
                tone_angle    = '0;
                envelope_drop = '0;
                r.beat        = 1'b1;
            end
            else
            begin
                beat_phase    = next_phase[SPB_W-1:0];
                tone_angle    = tone_angle + click_cfg.tone_step;
                drop_sum      = envelope_drop + click_cfg.env_step;
                envelope_drop = (drop_sum > DROP_MAX) ? DROP_MAX : drop_sum[DROP_W-1:0];
            end
            if (beat_phase < click_cfg.click_len)
            begin
                quad = tone_angle[ANGLE_W-1:QUAD_LO];
                idx  = int'((64'(tone_angle[QUAD_LO-1:0]) * SINE_DEPTH_DEF) >> QUAD_LO);
                if (idx > SINE_DEPTH_DEF)
                begin
                    idx = SINE_DEPTH_DEF;
                end
                amp  = (click_cfg.volume > envelope_drop) ? click_cfg.volume - envelope_drop : '0;
                sv   = quad[0] ? sine_table[SINE_DEPTH_DEF - idx] : sine_table[idx];
                prod = sv * amp + 33'd16384;
                mag  = prod[ROUND_SH +: MAG_W];
                click = quad[1] ? -int'(mag) : int'(mag);
            end
            active = (click_cfg.ch_count > LANE_LIMIT) ? LANE_LIMIT : int'(click_cfg.ch_count);
            for (int c = 0; c < active; c++)
            begin
                lane[c] = lane[c] + click;
            end
        end
        r.ch0 = clamp16(lane[0]);
        r.ch1 = clamp16(lane[1]);
        r.eob = f.eob;
        return r;
    endfunction

    // driver: a new frame is offered once the previous transfer is done
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_mixes.push_back(mix_frame(current_frame));
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_frames.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    current_frame = pending_frames.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {current_frame.ch1, current_frame.ch0};
                    s_axis_tuser  <= current_frame.restart;
                    s_axis_tlast  <= current_frame.eob;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic report_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h got %h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // monitor
    always @(posedge clk)
    begin : monitor
        mixed_frame_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_mixes.size() == 0)
                begin
                    $display("%0t: no frame expected, got data %h user %b last %b", $time,
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_mixes.pop_front();
                    report_field("mixed_ch0", want.ch0, m_axis_tdata[15:0]);
                    report_field("mixed_ch1", want.ch1, m_axis_tdata[31:16]);
                    report_field("beat_start", 16'(want.beat), 16'(m_axis_tuser));
                    report_field("block_end", 16'(want.eob), 16'(m_axis_tlast));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [2:0] index, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_ENABLE:    click_cfg.enable    = value[0];
            REG_SPB:       click_cfg.spb       = value[SPB_W-1:0];
            REG_CLICK_LEN: click_cfg.click_len = value[CLEN_W-1:0];
            REG_TONE_STEP: click_cfg.tone_step = value[ANGLE_W-1:0];
            REG_VOLUME:    click_cfg.volume    = value[VOL_W-1:0];
            REG_ENV_STEP:  click_cfg.env_step  = value[VOL_W-1:0];
            REG_CH_COUNT:  click_cfg.ch_count  = value[CNT_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic load_settings(input cfg_t c);
        write_reg(REG_ENABLE, 32'(c.enable));
        write_reg(REG_SPB, 32'(c.spb));
        write_reg(REG_CLICK_LEN, 32'(c.click_len));
        write_reg(REG_TONE_STEP, 32'(c.tone_step));
        write_reg(REG_VOLUME, 32'(c.volume));
        write_reg(REG_ENV_STEP, 32'(c.env_step));
        write_reg(REG_CH_COUNT, 32'(c.ch_count));
    endtask

    function automatic cfg_t make_settings(input logic en, input int spb, input int clen,
                                           input int step, input int vol, input int env,
                                           input int count);
        cfg_t c;
        c.enable    = en;
        c.spb       = spb[SPB_W-1:0];
        c.click_len = clen[CLEN_W-1:0];
        c.tone_step = step[ANGLE_W-1:0];
        c.volume    = vol[VOL_W-1:0];
        c.env_step  = env[VOL_W-1:0];
        c.ch_count  = count[CNT_W-1:0];
        return c;
    endfunction

    // short beats and long clicks most of the time so that clicks are frequent
    function automatic cfg_t random_settings();
        int spb;
        spb = ($urandom_range(9) == 0) ? $urandom_range(262143) : $urandom_range(1, 120);
        return make_settings($urandom_range(9) != 0, spb, $urandom_range(0, spb + 2),
                             $urandom, ($urandom_range(3) == 0) ? $urandom_range(65535)
                                                                : $urandom_range(32768),
                             ($urandom_range(3) == 0) ? $urandom_range(65535)
                                                      : $urandom_range(600),
                             $urandom_range(3));
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic push_frame(input logic [15:0] a, input logic [15:0] b,
                              input logic restart, input logic eob);
        dry_frame_t f;
        f.ch0     = a;
        f.ch1     = b;
        f.restart = restart;
        f.eob     = eob;
        pending_frames.push_back(f);
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_frames.size() != 0 || s_axis_tvalid || expected_mixes.size() != 0);
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 60; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 60; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
        endcase
    endtask

    initial
    begin
        for (int i = 0; i < SINE_DEPTH_DEF; i++)
        begin
            logic [63:0] v;
            v = (quarter_sine_q30((64'(i) * PI_HALF_Q30) / 64'(SINE_DEPTH_DEF)) * 64'd32767
                 + (64'd1 << 29)) >> 30;
            sine_table[i] = (v > 64'd32767) ? SINE_PEAK : v[SINE_W-1:0];
        end
        sine_table[SINE_DEPTH_DEF] = SINE_PEAK;
        click_cfg     = make_settings(1'b0, 24000, 480, 349525, 16384, 34, 2);
        beat_phase    = '0;
        tone_angle    = '0;
        envelope_drop = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // quarter-turn steps land on every quadrant edge, full volume saturates
        load_settings(make_settings(1'b1, 10, 8, 24'h400000, 32768, 0, 2));
        push_frame(16'h7FFF, 16'h7FFF, 1'b0, 1'b0);
        push_frame(16'h8000, 16'h8000, 1'b0, 1'b1);
        push_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0);
        push_frame(16'h1234, 16'h8001, 1'b0, 1'b0);
        push_frame(16'h7FFE, 16'h0001, 1'b1, 1'b0);
        for (int i = 0; i < 9; i++)
        begin
            push_frame(16'(i * 7919), ~16'(i * 7919), 1'b0, i == 8);
        end
        wait_drained();

        // beat length zero and one, channel count zero and above the number of lanes
        load_settings(make_settings(1'b1, 0, 1, 24'h123456, 20000, 100, 0));
        push_frame(16'h4000, 16'hC000, 1'b0, 1'b0);
        push_frame(16'h0001, 16'hFFFE, 1'b1, 1'b1);
        wait_drained();
        load_settings(make_settings(1'b1, 1, 65535, 24'h0ABCDE, 30000, 7, 3));
        push_frame(16'h7000, 16'h9000, 1'b0, 1'b0);
        push_frame(16'h7FFF, 16'h8000, 1'b1, 1'b0);
        wait_drained();

        // disabled: pass-through, restart still clears the state
        load_settings(make_settings(1'b0, 50, 40, 24'h200000, 32768, 0, 2));
        push_frame(16'h5A5A, 16'hA5A5, 1'b1, 1'b1);
        push_frame(16'h7FFF, 16'h8000, 1'b0, 1'b0);
        wait_drained();

        // envelope drop saturates, volume above unity, angle wraps
        load_settings(make_settings(1'b1, 262143, 65535, 24'hFFFFFF, 65535, 65535, 1));
        push_frame(16'h0000, 16'h0000, 1'b1, 1'b0);
        push_frame(16'h8000, 16'h7FFF, 1'b0, 1'b0);
        push_frame(16'h7FFF, 16'h8000, 1'b0, 1'b1);
        wait_drained();

        // no click length, no volume
        load_settings(make_settings(1'b1, 5, 0, 24'h100000, 0, 0, 2));
        push_frame(16'h1111, 16'h2222, 1'b0, 1'b0);
        push_frame(16'hEEEE, 16'hDDDD, 1'b1, 1'b1);
        wait_drained();

        for (int p = 0; p < 10; p++)
        begin
            load_settings(random_settings());
            set_idling(p);
            for (int n = 0; n < 50; n++)
            begin
                push_frame(pick_sample(), pick_sample(), $urandom_range(99) < 4,
                           $urandom_range(1) == 1);
            end
            wait_drained();
            set_idling(0);
        end

        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("metronome_click_mixer: match");
        end
        else
        begin
            $display("metronome_click_mixer: mismatch");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("metronome_click_mixer: mismatch");
        $finish;
    end

endmodule
